// File: hdl/cea_pkg.sv
// Shared word types and code constants for the effective-address unit.
package cea_pkg;

    // Input word opcodes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Result word kinds
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Addressing modes; codes above MODE_IND finish at once
    localparam logic [3:0] MODE_IMM  = 4'd0;
    localparam logic [3:0] MODE_ZP   = 4'd1;
    localparam logic [3:0] MODE_ZPX  = 4'd2;
    localparam logic [3:0] MODE_ZPY  = 4'd3;
    localparam logic [3:0] MODE_ABS  = 4'd4;
    localparam logic [3:0] MODE_ABSX = 4'd5;
    localparam logic [3:0] MODE_ABSY = 4'd6;
    localparam logic [3:0] MODE_INDX = 4'd7;
    localparam logic [3:0] MODE_INDY = 4'd8;
    localparam logic [3:0] MODE_IND  = 4'd9;

    // Operand step counter values
    localparam logic [1:0] STEP_0 = 2'd0;
    localparam logic [1:0] STEP_1 = 2'd1;
    localparam logic [1:0] STEP_2 = 2'd2;

    typedef struct packed {
        logic        op;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  x_index;
        logic [7:0]  y_index;
        logic [7:0]  read_data;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [15:0] bus_address;
        logic [15:0] next_pc;
        logic        page_crossed;
    } t_out_word;

endpackage

// File: hdl/cpu_effective_address_unit.sv
// Effective-address unit: operand fetch sequencing and address formation.
// The result word for an accepted input word is registered and appears in the cycle after it is accepted.
// Throughput: one input word per cycle; each word yields at most one result.
// The result register stalls the input only while it is full and stalled.
// Reset (synchronous, active low) clears the sequencer state and empties
// the result register.
module cpu_effective_address_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cea_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cea_pkg::t_out_word o_out_word
);
    import cea_pkg::*;

    // Sequencer state
    logic        r_busy,      n_busy;
    logic [3:0]  r_mode,      n_mode;
    logic [1:0]  r_step,      n_step;
    logic [15:0] r_saved_pc,  n_saved_pc;
    logic [7:0]  r_saved_x,   n_saved_x;
    logic [7:0]  r_saved_y,   n_saved_y;
    logic [7:0]  r_low_byte,  n_low_byte;
    logic [15:0] r_pointer,   n_pointer;

    // Result register
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        in_accept;
    logic        res_valid;
    t_out_word   res_word;

    // Datapath helpers
    logic [7:0]  data;
    logic [7:0]  idx;
    logic [8:0]  low_sum;
    logic [15:0] base;
    logic [7:0]  ptr_inc;

    // Result register can take a word when empty or draining this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign data = i_in_word.read_data;

    always_comb begin
        // index for the absolute indexed and indirect-indexed adds
        unique case (r_mode)
            MODE_ABSX: idx = r_saved_x;
            MODE_ABSY,
            MODE_INDY: idx = r_saved_y;
            default:   idx = 8'h00;
        endcase
        low_sum = {1'b0, r_low_byte} + {1'b0, idx};
        base    = {data, r_low_byte};
        ptr_inc = r_pointer[7:0] + 8'd1;
    end

    always_comb begin
        n_busy     = r_busy;
        n_mode     = r_mode;
        n_step     = r_step;
        n_saved_pc = r_saved_pc;
        n_saved_x  = r_saved_x;
        n_saved_y  = r_saved_y;
        n_low_byte = r_low_byte;
        n_pointer  = r_pointer;
        res_valid  = 1'b0;
        res_word   = '0;

        if (i_in_word.op == OP_BEGIN) begin
            // begin always restarts, abandoning any walk in progress
            n_mode     = i_in_word.mode;
            n_saved_pc = i_in_word.pc;
            n_saved_x  = i_in_word.x_index;
            n_saved_y  = i_in_word.y_index;
            n_low_byte = 8'h00;
            n_pointer  = 16'h0000;
            n_step     = STEP_0;
            res_valid  = 1'b1;
            if (i_in_word.mode == MODE_IMM) begin
                n_busy   = 1'b0;
                res_word = '{KIND_DONE, i_in_word.pc, i_in_word.pc + 16'd1, 1'b0};
            end else if (i_in_word.mode > MODE_IND) begin
                // unknown mode: done at once, pc unchanged
                n_busy   = 1'b0;
                res_word = '{KIND_DONE, i_in_word.pc, i_in_word.pc, 1'b0};
            end else begin
                n_busy   = 1'b1;
                res_word = '{KIND_REQ, i_in_word.pc, 16'h0000, 1'b0};
            end
        end else if (r_busy) begin
            res_valid = 1'b1;
            // default assumes done; request arms override
            n_busy = 1'b0;
            n_step = STEP_0;
            unique case (r_mode)
                MODE_ZP: begin
                    res_word = '{KIND_DONE, {8'h00, data}, r_saved_pc + 16'd1, 1'b0};
                end
                MODE_ZPX: begin
                    res_word = '{KIND_DONE, {8'h00, data + r_saved_x},
                                 r_saved_pc + 16'd1, 1'b0};
                end
                MODE_ZPY: begin
                    res_word = '{KIND_DONE, {8'h00, data + r_saved_y},
                                 r_saved_pc + 16'd1, 1'b0};
                end
                MODE_ABS, MODE_ABSX, MODE_ABSY: begin
                    if (r_step == STEP_0) begin
                        n_busy     = 1'b1;
                        n_step     = r_step + 2'd1;
                        n_low_byte = data;
                        res_word   = '{KIND_REQ, r_saved_pc + 16'd1, 16'h0000, 1'b0};
                    end else begin
                        res_word = '{KIND_DONE, base + {8'h00, idx},
                                     r_saved_pc + 16'd2, low_sum[8]};
                    end
                end
                MODE_INDX, MODE_INDY: begin
                    if (r_step == STEP_0) begin
                        // zero-page pointer, pre-indexed by X for indx
                        n_busy    = 1'b1;
                        n_step    = r_step + 2'd1;
                        n_pointer = {8'h00,
                                     (r_mode == MODE_INDX) ? data + r_saved_x : data};
                        res_word  = '{KIND_REQ, n_pointer, 16'h0000, 1'b0};
                    end else if (r_step == STEP_1) begin
                        n_busy     = 1'b1;
                        n_step     = r_step + 2'd1;
                        n_low_byte = data;
                        res_word   = '{KIND_REQ, {8'h00, ptr_inc}, 16'h0000, 1'b0};
                    end else begin
                        res_word = '{KIND_DONE, base + {8'h00, idx},
                                     r_saved_pc + 16'd1, low_sum[8]};
                    end
                end
                MODE_IND: begin
                    if (r_step == STEP_0) begin
                        n_busy     = 1'b1;
                        n_step     = r_step + 2'd1;
                        n_low_byte = data;
                        res_word   = '{KIND_REQ, r_saved_pc + 16'd1, 16'h0000, 1'b0};
                    end else if (r_step == STEP_1) begin
                        n_busy    = 1'b1;
                        n_step    = r_step + 2'd1;
                        n_pointer = base;
                        res_word  = '{KIND_REQ, base, 16'h0000, 1'b0};
                    end else if (r_step == STEP_2) begin
                        // high byte stays in the pointer's page (wrap bug)
                        n_busy     = 1'b1;
                        n_step     = r_step + 2'd1;
                        n_low_byte = data;
                        res_word   = '{KIND_REQ, {r_pointer[15:8], ptr_inc},
                                       16'h0000, 1'b0};
                    end else begin
                        res_word = '{KIND_DONE, base, r_saved_pc, 1'b0};
                    end
                end
                default: begin
                    // not reachable while busy; drop the word
                    res_valid = 1'b0;
                end
            endcase
        end
        // read data while idle: ignored
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mode      <= MODE_IMM;
            r_step      <= STEP_0;
            r_saved_pc  <= 16'h0000;
            r_saved_x   <= 8'h00;
            r_saved_y   <= 8'h00;
            r_low_byte  <= 8'h00;
            r_pointer   <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_busy     <= n_busy;
                r_mode     <= n_mode;
                r_step     <= n_step;
                r_saved_pc <= n_saved_pc;
                r_saved_x  <= n_saved_x;
                r_saved_y  <= n_saved_y;
                r_low_byte <= n_low_byte;
                r_pointer  <= n_pointer;
            end
            if (in_accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: hdl/cea_checker.sv
// Port-level checker for the effective-address unit and its bind.
module cea_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input cea_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cea_pkg::t_out_word o_out_word
);
    import cea_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_imm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.op == OP_BEGIN &&
        i_in_word.mode == MODE_IMM
        |=> o_out_valid && o_out_word.kind == KIND_DONE &&
            o_out_word.bus_address == $past(i_in_word.pc))
        else $error("immediate begin did not finish at pc");

    a_req_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == KIND_REQ
        |-> o_out_word.next_pc == 16'h0000 && !o_out_word.page_crossed)
        else $error("read request carries done fields");

endmodule

bind cpu_effective_address_unit cea_checker u_cea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
